@@ design/u2da_pkg.sv @@
`default_nettype none

package u2da_pkg;

  // Fixed field widths of the two channels.
  localparam int IN_BITS       = 32;
  localparam int CHAR_BITS     = 6;
  localparam int DIGIT_BITS    = 4;
  localparam int VALUE_BITS_DEF = 32;

  // ASCII code of the character '0'.
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

  // Division by ten as a multiply by ceil(2^35 / 10) and a right shift.
  // The result is exact for every operand below 2^32.
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          RECIP_BITS  = 32;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } u2da_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic pop;
  } u2da_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_zero;
    logic in_prec;
    logic quot_zero;
    logic last;
  } u2da_sts_t;

endpackage

`default_nettype wire

@@ design/u2da_stream_if.sv @@
`default_nettype none

// Input channel: one value to convert per transfer.
interface u2da_in_if
  import u2da_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [IN_BITS-1:0] value;
  logic               precision_given;

  modport source (output valid, output value, output precision_given, input ready);
  modport sink   (input valid, input value, input precision_given, output ready);
endinterface

// Result channel: one ASCII digit per transfer.
interface u2da_out_if
  import u2da_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] digit_char;
  logic                 last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

@@ design/u2da_ctrl.sv @@
`default_nettype none

module u2da_ctrl
  import u2da_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output u2da_cmd_t      cmd,
  input  wire u2da_sts_t sts
);

  u2da_state_t state_r;
  u2da_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // A zero value either prints one '0' or, with a precision, nothing.
          if (sts.in_zero) begin
            state_nxt = sts.in_prec ? ST_IDLE : ST_EMIT;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = sts.quot_zero ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.pop = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/u2da_dpath.sv @@
`default_nettype none

module u2da_dpath
  import u2da_pkg::*;
#(
  parameter int OP_BITS    = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = 10,
  parameter int CNT_BITS   = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire u2da_cmd_t            cmd,
  output u2da_sts_t                 sts,
  input  wire logic [IN_BITS-1:0]   in_value,
  input  wire logic                 in_precision_given,
  output logic [CHAR_BITS-1:0]      out_digit_char,
  output logic                      out_last_digit
);

  localparam int PROD_BITS = OP_BITS + RECIP_BITS;

  logic [OP_BITS-1:0]    value_r;
  logic [OP_BITS-1:0]    value_nxt;
  logic [PROD_BITS-1:0]  prod_r;
  logic [CNT_BITS-1:0]   count_r;
  logic [CNT_BITS-1:0]   count_nxt;
  logic [DIGIT_BITS-1:0] stack_r   [MAX_DIGITS];
  logic [DIGIT_BITS-1:0] stack_nxt [MAX_DIGITS];

  logic [OP_BITS-1:0]    in_op;
  logic [OP_BITS-1:0]    quot;
  logic [OP_BITS+3:0]    quot_x10;
  logic [DIGIT_BITS-1:0] rem;

  // Operand masked to the configured width.
  assign in_op = in_value[OP_BITS-1:0];

  // Quotient and remainder of the current value by ten.
  assign quot     = OP_BITS'(prod_r >> RECIP_SHIFT);
  assign quot_x10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign rem      = value_r[DIGIT_BITS-1:0] - quot_x10[DIGIT_BITS-1:0];

  // Status for the controller.
  assign sts.in_zero   = (in_op == '0);
  assign sts.in_prec   = in_precision_given;
  assign sts.quot_zero = (quot == '0);
  assign sts.last      = (count_r == CNT_BITS'(1));

  // Most significant digit sits at the top of the digit stack.
  assign out_digit_char = ASCII_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, stack_r[0]};
  assign out_last_digit = sts.last;

  // Digit stack: digits are pushed least significant first, popped from the top.
  always_comb begin
    value_nxt = value_r;
    count_nxt = count_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      stack_nxt[i] = stack_r[i];
    end
    priority if (cmd.load) begin
      value_nxt    = in_op;
      count_nxt    = (in_op == '0) ? CNT_BITS'(1) : '0;
      stack_nxt[0] = '0;
    end else if (cmd.div) begin
      value_nxt    = quot;
      count_nxt    = count_r + CNT_BITS'(1);
      stack_nxt[0] = rem;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        stack_nxt[i] = stack_r[i-1];
      end
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_BITS'(1);
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        stack_nxt[i] = stack_r[i+1];
      end
    end else begin
      // No load, divide or pop: value, count and digits hold.
      value_nxt = value_r;
    end
  end

  // Digit count is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Payload registers: working value, product and digits.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (cmd.mul) begin
      prod_r <= PROD_BITS'(value_r) * PROD_BITS'(RECIP_TEN);
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      stack_r[i] <= stack_nxt[i];
    end
  end

endmodule

`default_nettype wire

@@ design/unsigned_to_decimal_ascii_unit.sv @@
`default_nettype none

// Channel   Role    Payload                       Handshake
// in_chan   sink    value[31:0], precision_given  valid/ready
// out_chan  source  digit_char[5:0], last_digit   valid/ready
//
// One value at a time. A nonzero value with n digits is divided by ten n
// times, each a multiply step and then a quotient/remainder step (states
// ST_MUL and ST_DIV), and is then sent as n output transfers. A zero value
// gives its single transfer, or none with a precision. Reset is synchronous
// and returns the unit to idle.
// A stalled result holds its digit; the input is not taken until the last
// digit of the current value has been transferred.

module unsigned_to_decimal_ascii_unit
  import u2da_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  u2da_in_if.sink     in_chan,
  u2da_out_if.source  out_chan
);

  localparam int OP_BITS    = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
  localparam int MAX_DIGITS = ((OP_BITS * 1233) >> 12) + 1;
  localparam int CNT_BITS   = $clog2(MAX_DIGITS + 1);

  u2da_cmd_t cmd;
  u2da_sts_t sts;
  logic      ctrl_in_ready;
  logic      ctrl_out_valid;

  // Controller.
  u2da_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (ctrl_in_ready),
    .out_valid (ctrl_out_valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath.
  u2da_dpath #(
    .OP_BITS    (OP_BITS),
    .MAX_DIGITS (MAX_DIGITS),
    .CNT_BITS   (CNT_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_value           (in_chan.value),
    .in_precision_given (in_chan.precision_given),
    .out_digit_char     (out_chan.digit_char),
    .out_last_digit     (out_chan.last_digit)
  );

  assign in_chan.ready  = ctrl_in_ready;
  assign out_chan.valid = ctrl_out_valid;

  // A shown result is always a decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.digit_char >= ASCII_ZERO &&
                        out_chan.digit_char <= ASCII_ZERO + 6'd9))
    else $error("digit_char out of range");

  // Input and output are never open at the same time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !out_chan.valid)
    else $error("input taken while a result is shown");

  // Zero with a precision produces nothing and leaves the unit idle.
  a_zero_prec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && sts.in_zero && in_chan.precision_given)
      |=> (in_chan.ready && !out_chan.valid))
    else $error("zero with precision did not return to idle");

  // The transfer of the last digit returns the unit to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.last_digit) |=> in_chan.ready)
    else $error("unit busy after last digit");

endmodule

`default_nettype wire

@@ sim/u2da_digit_checker.sv @@
// Watches both channels, predicts the digit string of every accepted value
// and compares each transferred digit against the oldest expected one.
module u2da_digit_checker
  import u2da_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  u2da_in_if   in_mon,
  u2da_out_if  out_mon,
  output int   mismatch_count,
  output int   digits_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;
  } digit_expect_t;

  digit_expect_t expected_digits[$];

  initial begin
    mismatch_count = 0;
    digits_pending = 0;
  end

  // Queue the decimal digits of one value, most significant first.
  // A zero gives a lone '0' unless a precision was given, then nothing.
  function automatic void queue_decimal_digits(logic [IN_BITS-1:0] raw, logic prec);
    logic [63:0]     operand;
    logic [63:0]     operand_mask;
    logic [3:0]      reversed[$];
    digit_expect_t   entry;
    operand_mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    operand = {32'd0, raw} & operand_mask;
    if (operand == 64'd0) begin
      if (!prec) begin
        entry.digit_char = ASCII_ZERO;
        entry.last_digit = 1'b1;
        expected_digits.push_back(entry);
      end
      return;
    end
    while (operand != 64'd0) begin
      reversed.push_back(4'(operand % 64'd10));
      operand = operand / 64'd10;
    end
    for (int k = reversed.size() - 1; k >= 0; k--) begin
      entry.digit_char = CHAR_BITS'(ASCII_ZERO + reversed[k]);
      entry.last_digit = (k == 0);
      expected_digits.push_back(entry);
    end
  endfunction

  // Only the first few mismatches are printed; the rest are just counted.
  task automatic note_mismatch(string what);
    if (mismatch_count < 10) begin
      $display("[%0t] digit mismatch: %s", $time, what);
    end
    mismatch_count <= mismatch_count + 1;
  endtask

  // Predict on every input transfer, compare on every result transfer.
  always @(posedge clk) begin
    digit_expect_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        queue_decimal_digits(in_mon.value, in_mon.precision_given);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_digits.size() == 0) begin
          note_mismatch($sformatf("unexpected digit char=%0d last=%0b",
                                  out_mon.digit_char, out_mon.last_digit));
        end else begin
          want = expected_digits.pop_front();
          if (out_mon.digit_char !== want.digit_char ||
              out_mon.last_digit !== want.last_digit) begin
            note_mismatch($sformatf("expected char=%0d last=%0b, got char=%0d last=%0b",
                                    want.digit_char, want.last_digit,
                                    out_mon.digit_char, out_mon.last_digit));
          end
        end
      end
    end
    digits_pending <= expected_digits.size();
  end

endmodule

@@ sim/unsigned_to_decimal_ascii_unit_tb.sv @@
// Drives values into the converter, stalls the digit stream at random and
// gives the verdict from the checker's mismatch count and pending digits.
module unsigned_to_decimal_ascii_unit_tb;
  import u2da_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_VALUES  = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 40;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   digits_pending;
  int   quiet_cycles;
  logic calm;
  logic hold_req;

  u2da_in_if  in_if();
  u2da_out_if out_if();

  unsigned_to_decimal_ascii_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  u2da_digit_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .mismatch_count (mismatch_count),
    .digits_pending (digits_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one value, idling beforehand now and then, and wait for its transfer.
  task automatic offer_value(input logic [IN_BITS-1:0] v, input logic prec);
    while (!calm && $urandom_range(99, 0) < 17) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.value           <= v;
    in_if.precision_given <= prec;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Mostly values of a random digit count, some full-width words, a few zeros.
  function automatic logic [IN_BITS-1:0] pick_value();
    int unsigned    sel;
    int unsigned    ndig;
    longint unsigned lo;
    longint unsigned hi;
    sel = $urandom_range(99, 0);
    if (sel < 6) return '0;
    if (sel < 26) return $urandom();
    ndig = $urandom_range(10, 1);
    lo = 1;
    repeat (ndig - 1) lo = lo * 10;
    hi = (ndig == 10) ? 64'hFFFF_FFFF : lo * 10 - 1;
    return $urandom_range(32'(hi), 32'(lo));
  endfunction

  // Stimulus, end of run and verdict.
  initial begin
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.value           <= '0;
    in_if.precision_given <= 1'b0;
    calm                  = 1'b0;
    hold_req              = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed values: zero both ways, digit-count boundaries, all ones.
    offer_value(32'd0, 1'b0);
    offer_value(32'd0, 1'b1);
    offer_value(32'd1, 1'b0);
    offer_value(32'd1, 1'b1);
    offer_value(32'd9, 1'b0);
    offer_value(32'd10, 1'b0);
    offer_value(32'd99, 1'b1);
    offer_value(32'd100, 1'b0);
    offer_value(32'd1234567890, 1'b0);
    offer_value(32'd999999999, 1'b0);
    offer_value(32'd1000000000, 1'b1);
    offer_value(32'hFFFF_FFFF, 1'b0);
    offer_value(32'hFFFF_FFFF, 1'b1);
    offer_value(32'h8000_0000, 1'b0);
    offer_value(32'h5555_5555, 1'b0);
    offer_value(32'hAAAA_AAAA, 1'b1);
    offer_value(32'd0, 1'b0);
    offer_value(32'd4000000000, 1'b0);
    offer_value(32'd7, 1'b1);

    // Random values, with one long output hold-off and one calm stretch.
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i == 50) hold_req = 1'b1;
      calm = (i >= 150 && i < 200);
      offer_value(pick_value(), 1'($urandom_range(1, 0)));
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (digits_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && digits_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Digit receiver: random stalls, one long hold-off, no stalls when calm.
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (calm) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99, 0) >= 17);
      end
    end
  end

  // Watchdog: too many cycles in a row without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
